// ----- hdl/bpe_pkg.sv -----
// ---------------------------------------------------------------------------
// bpe_pkg
// Shared item types, codes and controller/datapath interface structs for the
// byte pair merge engine.
// ---------------------------------------------------------------------------
package bpe_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] table_index;
    logic [17:0] left_id;
    logic [17:0] right_id;
    logic [17:0] result_id;
    logic [17:0] merge_rank;
    logic        byte_present;
    logic [7:0]  text_byte;
    logic        end_of_piece;
  } in_t;

  typedef struct packed {
    logic [17:0] token_val;
    logic        last_token;
    logic [1:0]  status;
  } out_t;

  localparam logic [1:0] OP_MERGE = 2'd0;
  localparam logic [1:0] OP_MAP   = 2'd1;
  localparam logic [1:0] OP_TEXT  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMAP    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_merge;
    logic load_map;
    logic take_byte;
    logic apply_byte;
    logic err_out;
    logic round_start;
    logic pair_left;
    logic pair_right;
    logic search_issue;
    logic probe;
    logic next_pair;
    logic replace;
    logic shift_rd;
    logic shift_wr;
    logic shrink;
    logic emit_start;
    logic emit_rd;
    logic emit_wr;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic eop;
    logic err_nz;
    logic len_ge2;
    logic lo_lt_hi;
    logic probe_eq;
    logic more_pairs;
    logic have;
    logic shift_more;
    logic emit_more;
    logic emit_last;
    logic slot_free;
  } sts_t;

endpackage

// ----- hdl/bpe_ctrl.sv -----
// ---------------------------------------------------------------------------
// bpe_ctrl
// Sequencer for loads, byte buffering, merge rounds and token emission.
// ---------------------------------------------------------------------------
module bpe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_ready,
  input  bpe_pkg::sts_t    sts,
  output bpe_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_BYTE     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_ERR      = 4'd3;
  localparam logic [3:0] S_ROUND    = 4'd4;
  localparam logic [3:0] S_PAIR_L   = 4'd5;
  localparam logic [3:0] S_PAIR_R   = 4'd6;
  localparam logic [3:0] S_SEARCH   = 4'd7;
  localparam logic [3:0] S_PROBE    = 4'd8;
  localparam logic [3:0] S_NEXT     = 4'd9;
  localparam logic [3:0] S_SHIFT_RD = 4'd10;
  localparam logic [3:0] S_SHIFT_WR = 4'd11;
  localparam logic [3:0] S_EMIT_RD  = 4'd12;
  localparam logic [3:0] S_EMIT_WR  = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            bpe_pkg::OP_MERGE: cmd.load_merge = 1'b1;
            bpe_pkg::OP_MAP:   cmd.load_map = 1'b1;
            bpe_pkg::OP_TEXT: begin
              cmd.take_byte = 1'b1;
              state_nxt     = S_BYTE;
            end
            default: ;
          endcase
        end
      end
      S_BYTE: begin
        cmd.apply_byte = 1'b1;
        state_nxt      = sts.eop ? S_CHECK : S_IDLE;
      end
      S_CHECK: state_nxt = sts.err_nz ? S_ERR : S_ROUND;
      S_ERR: begin
        if (sts.slot_free) begin
          cmd.err_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_ROUND: begin
        if (sts.len_ge2) begin
          cmd.round_start = 1'b1;
          state_nxt       = S_PAIR_L;
        end else begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT_RD;
        end
      end
      S_PAIR_L: begin
        cmd.pair_left = 1'b1;
        state_nxt     = S_PAIR_R;
      end
      S_PAIR_R: begin
        cmd.pair_right = 1'b1;
        state_nxt      = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.lo_lt_hi) begin
          cmd.search_issue = 1'b1;
          state_nxt        = S_PROBE;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        state_nxt = sts.probe_eq ? S_NEXT : S_SEARCH;
      end
      S_NEXT: begin
        if (sts.more_pairs) begin
          cmd.next_pair = 1'b1;
          state_nxt     = S_PAIR_R;
        end else if (sts.have) begin
          cmd.replace = 1'b1;
          state_nxt   = S_SHIFT_RD;
        end else begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          cmd.shrink = 1'b1;
          state_nxt  = S_ROUND;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_EMIT_RD: begin
        if (!sts.emit_more) begin
          state_nxt = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_WR;
        end
      end
      S_EMIT_WR: begin
        cmd.emit_wr = 1'b1;
        state_nxt   = sts.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/bpe_dp.sv -----
// ---------------------------------------------------------------------------
// bpe_dp
// Merge table, byte map, span buffer, binary search registers and the
// output register.
// ---------------------------------------------------------------------------
module bpe_dp #(
  parameter int MERGE_DEPTH = 65536,
  parameter int MAX_SPAN    = 64,
  parameter int TOKEN_BITS  = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bpe_pkg::in_t                      in_data,
  input  logic [$clog2(MERGE_DEPTH+1)-1:0]  pair_limit,
  input  bpe_pkg::cmd_t                     cmd,
  output bpe_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bpe_pkg::out_t                     out_data
);

  localparam int TB = TOKEN_BITS;
  localparam int CW = $clog2(MERGE_DEPTH + 1);
  localparam int AW = (MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1;
  localparam int LW = $clog2(MAX_SPAN + 1);
  localparam int IW = $clog2(MAX_SPAN);
  localparam int EW = 3 * TB + 18;

  // Merge table: {left, right, result, rank}
  logic [EW-1:0] mrg_q [MERGE_DEPTH];
  logic [EW-1:0] mrg_rd_r;
  // Byte map
  logic          present_q [256];
  logic [TB-1:0] maptok_q [256];
  logic          present_r;
  logic [TB-1:0] maptok_r;
  // Span buffer
  logic [TB-1:0] span_q [MAX_SPAN];
  logic [TB-1:0] span_rd_r;

  logic          eop_r;
  logic [1:0]    err_r;
  logic [LW-1:0] len_r;
  logic [IW-1:0] i_r;
  logic [TB-1:0] left_r, right_r;
  logic [CW-1:0] lo_r, hi_r, mid_r;
  logic          have_r;
  logic [IW-1:0] best_pos_r;
  logic [TB-1:0] best_res_r;
  logic [17:0]   best_rank_r;
  logic [LW-1:0] j_r, k_r;
  logic          out_valid_r;
  bpe_pkg::out_t out_r;

  logic [31:0]   tidx32, left32, right32, res32, out32;
  logic [TB-1:0] left_tok, right_tok, res_tok;
  logic [CW-1:0] mid;
  logic [TB-1:0] m_left, m_right, m_res;
  logic [17:0]   m_rank;
  logic          key_eq, key_lt;
  logic          span_we;
  logic [IW-1:0] span_wa, span_ra;
  logic [TB-1:0] span_wd;
  logic [LW-1:0] i_plus1, i_plus2, j_plus1, k_plus1;

  assign tidx32    = 32'(in_data.table_index);
  assign left32    = 32'(in_data.left_id);
  assign right32   = 32'(in_data.right_id);
  assign res32     = 32'(in_data.result_id);
  assign left_tok  = left32[TB-1:0];
  assign right_tok = right32[TB-1:0];
  assign res_tok   = res32[TB-1:0];

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign {m_left, m_right, m_res, m_rank} = mrg_rd_r;
  assign key_eq = ({m_left, m_right} == {left_r, right_r});
  assign key_lt = ({m_left, m_right} <  {left_r, right_r});

  assign i_plus1 = LW'(i_r) + LW'(1);
  assign i_plus2 = LW'(i_r) + LW'(2);
  assign j_plus1 = j_r + LW'(1);
  assign k_plus1 = k_r + LW'(1);

  // Span port selection
  always_comb begin
    span_we = 1'b0;
    span_wa = len_r[IW-1:0];
    span_wd = maptok_r;
    if (cmd.apply_byte && err_r == bpe_pkg::ST_OK && present_r &&
        len_r < LW'(MAX_SPAN)) begin
      span_we = 1'b1;
    end else if (cmd.replace) begin
      span_we = 1'b1;
      span_wa = best_pos_r;
      span_wd = best_res_r;
    end else if (cmd.shift_wr) begin
      span_we = 1'b1;
      span_wa = j_r[IW-1:0];
      span_wd = span_rd_r;
    end
    span_ra = '0;
    if (cmd.pair_left) begin
      span_ra = i_plus1[IW-1:0];
    end else if (cmd.next_pair) begin
      span_ra = i_plus2[IW-1:0];
    end else if (cmd.shift_rd) begin
      span_ra = j_plus1[IW-1:0];
    end else if (cmd.emit_rd) begin
      span_ra = k_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (span_we) begin
      span_q[span_wa] <= span_wd;
    end
    span_rd_r <= span_q[span_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_merge && tidx32 < 32'(MERGE_DEPTH)) begin
      mrg_q[tidx32[AW-1:0]] <= {left_tok, right_tok, res_tok, in_data.merge_rank};
    end
    mrg_rd_r <= mrg_q[mid[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_map && tidx32 < 32'd256) begin
      maptok_q[tidx32[7:0]] <= res_tok;
    end
    maptok_r <= maptok_q[in_data.text_byte];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 256; b++) begin
        present_q[b] <= 1'b0;
      end
    end else if (cmd.load_map && tidx32 < 32'd256) begin
      present_q[tidx32[7:0]] <= in_data.byte_present;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      present_r <= present_q[in_data.text_byte];
      eop_r     <= in_data.end_of_piece;
    end
    if (cmd.round_start) begin
      i_r    <= '0;
      have_r <= 1'b0;
    end
    if (cmd.pair_left) begin
      left_r <= span_rd_r;
    end
    if (cmd.pair_right) begin
      right_r <= span_rd_r;
      lo_r    <= '0;
      hi_r    <= pair_limit;
    end
    if (cmd.search_issue) begin
      mid_r <= mid;
    end
    if (cmd.probe) begin
      if (key_eq) begin
        if (!have_r || m_rank < best_rank_r) begin
          have_r      <= 1'b1;
          best_pos_r  <= i_r;
          best_res_r  <= m_res;
          best_rank_r <= m_rank;
        end
      end else if (key_lt) begin
        lo_r <= mid_r + CW'(1);
      end else begin
        hi_r <= mid_r;
      end
    end
    if (cmd.next_pair) begin
      left_r <= right_r;
      i_r    <= i_plus1[IW-1:0];
    end
    if (cmd.replace) begin
      j_r <= LW'(best_pos_r) + LW'(1);
    end
    if (cmd.shift_wr) begin
      j_r <= j_plus1;
    end
    if (cmd.emit_start) begin
      k_r <= '0;
    end
    if (cmd.emit_wr) begin
      k_r <= k_plus1;
    end
  end

  // Control state: span length, sticky error, output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      err_r       <= bpe_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.apply_byte && err_r == bpe_pkg::ST_OK) begin
        if (!present_r) begin
          err_r <= bpe_pkg::ST_NOMAP;
        end else if (len_r >= LW'(MAX_SPAN)) begin
          err_r <= bpe_pkg::ST_OVERFLOW;
        end else begin
          len_r <= len_r + LW'(1);
        end
      end
      if (cmd.err_out) begin
        out_valid_r <= 1'b1;
        err_r       <= bpe_pkg::ST_OK;
        len_r       <= '0;
      end
      if (cmd.shrink) begin
        len_r <= len_r - LW'(1);
      end
      if (cmd.emit_wr) begin
        out_valid_r <= 1'b1;
        if (k_plus1 == len_r) begin
          len_r <= '0;
        end
      end
    end
  end

  assign out32 = 32'(span_rd_r);

  always_ff @(posedge clk) begin
    if (cmd.err_out) begin
      out_r.token_val  <= '0;
      out_r.last_token <= 1'b1;
      out_r.status     <= err_r;
    end else if (cmd.emit_wr) begin
      out_r.token_val  <= out32[17:0];
      out_r.last_token <= (k_plus1 == len_r);
      out_r.status     <= bpe_pkg::ST_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.eop        = eop_r;
    sts.err_nz     = (err_r != bpe_pkg::ST_OK);
    sts.len_ge2    = (len_r >= LW'(2));
    sts.lo_lt_hi   = (lo_r < hi_r);
    sts.probe_eq   = key_eq;
    sts.more_pairs = (i_plus2 < len_r);
    sts.have       = have_r;
    sts.shift_more = (j_plus1 < len_r);
    sts.emit_more  = (k_r < len_r);
    sts.emit_last  = (k_plus1 == len_r);
    sts.slot_free  = !out_valid_r || out_ready;
  end

endmodule

// ----- hdl/bpe_merge_engine.sv -----
// ---------------------------------------------------------------------------
// bpe_merge_engine
// Byte-level pair merge encoder for one pre-split text piece: table loads,
// byte mapping, merge rounds by binary search, token emission.
// ---------------------------------------------------------------------------
//
//  channel | ports                              | item
//  --------+------------------------------------+------------------------------
//  in      | in_valid / in_ready / in_data      | load entry or one text byte
//  out     | out_valid / out_ready / out_data   | one token or one error result
//  cfg     | psel penable pwrite paddr pwdata   | pair limit while paddr[2] is 0
//          | prdata pready                      |
//
//  A text byte takes a map read, then a span update. At end of piece each
//  round walks the adjacent pairs, each a pair read plus binary search
//  probes (one merge table read port, ceil(log2(count+1)) probes at most),
//  then shifts the entries behind the merge, a read and a write each; each
//  token leaves by a span read and an output write. in_ready is low from the
//  last byte until the final token is loaded into the output register.
//  Reset clears the byte map present bits, span length, error and the
//  pair limit; the merge table and span contents need no clearing.
//  A stalled output holds the engine only when a new result must be loaded.
// ---------------------------------------------------------------------------
module bpe_merge_engine #(
  parameter int MERGE_DEPTH = 65536,
  parameter int MAX_SPAN    = 64,
  parameter int TOKEN_BITS  = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bpe_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int CW = $clog2(MERGE_DEPTH + 1);

  bpe_pkg::cmd_t cmd;
  bpe_pkg::sts_t sts;

  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   wr_val;

  // Saturate the written count to the table depth
  assign wr_val    = 32'(pwdata[16:0]);
  assign count_nxt = (wr_val > 32'(MERGE_DEPTH)) ? CW'(MERGE_DEPTH) : wr_val[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      count_r <= count_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(count_r);

  bpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpe_dp #(
    .MERGE_DEPTH (MERGE_DEPTH),
    .MAX_SPAN    (MAX_SPAN),
    .TOKEN_BITS  (TOKEN_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .pair_limit  (count_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- hdl/bpe_checker.sv -----
// ---------------------------------------------------------------------------
// bpe_checker
// Port-level checks on the merge engine, bound to the top level.
// ---------------------------------------------------------------------------
module bpe_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input bpe_pkg::out_t out_data,
  input logic          psel,
  input logic          pwrite,
  input logic [31:0]   prdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Error results carry a zero token and close the piece
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != bpe_pkg::ST_OK |->
      out_data.token_val == 18'd0 && out_data.last_token)
    else $error("malformed error result");

  // Read-back count never exceeds the written field width
  a_count_width: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite |-> prdata[31:17] == 15'd0)
    else $error("count read-back too wide");

endmodule

bind bpe_merge_engine bpe_checker u_bpe_checker (.*);

// ----- tb/bpe_merge_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpe_merge_checker
// Watches the item, token and register ports of the merge engine, predicts
// the tokens of every piece and compares them in order.
// ---------------------------------------------------------------------------
module bpe_merge_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  bpe_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  bpe_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output int            mismatches,
  output int            tokens_owed
);

  logic [35:0]   pair_mem [int];
  logic [35:0]   outcome_mem [int];
  logic          byte_known [256];
  logic [17:0]   byte_token [256];
  logic [17:0]   span_q [$];
  logic [1:0]    piece_err;
  int            search_limit;
  bpe_pkg::out_t owed_q [$];

  // Binary search over the first search_limit entries, as the engine does.
  function automatic bit search_pairs(input logic [17:0] l, input logic [17:0] r,
                                      output logic [17:0] res,
                                      output logic [17:0] rank);
    logic [35:0] key;
    int lo, hi, mid;
    key = {l, r};
    lo = 0;
    hi = search_limit;
    res = '0;
    rank = '0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (pair_mem[mid] == key) begin
        res = outcome_mem[mid][35:18];
        rank = outcome_mem[mid][17:0];
        return 1'b1;
      end
      if (pair_mem[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  task automatic merge_span();
    bit have, hit;
    int best_pos;
    logic [17:0] best_res, best_rank, r, k;
    while (span_q.size() >= 2) begin
      have = 0;
      best_pos = 0;
      best_res = '0;
      best_rank = '0;
      for (int i = 0; i + 1 < span_q.size(); i++) begin
        hit = search_pairs(span_q[i], span_q[i+1], r, k);
        if (hit && (!have || k < best_rank)) begin
          have = 1;
          best_pos = i;
          best_res = r;
          best_rank = k;
        end
      end
      if (!have) return;
      span_q[best_pos] = best_res;
      span_q.delete(best_pos + 1);
    end
  endtask

  task automatic predict_item(input bpe_pkg::in_t it);
    bpe_pkg::out_t o;
    case (it.opcode)
      bpe_pkg::OP_MERGE: begin
        pair_mem[it.table_index] = {it.left_id, it.right_id};
        outcome_mem[it.table_index] = {it.result_id, it.merge_rank};
      end
      bpe_pkg::OP_MAP: begin
        if (it.table_index < 256) begin
          byte_known[it.table_index[7:0]] = it.byte_present;
          byte_token[it.table_index[7:0]] = it.result_id;
        end
      end
      bpe_pkg::OP_TEXT: begin
        if (piece_err == bpe_pkg::ST_OK) begin
          if (!byte_known[it.text_byte]) piece_err = bpe_pkg::ST_NOMAP;
          else if (span_q.size() >= 64) piece_err = bpe_pkg::ST_OVERFLOW;
          else span_q.push_back(byte_token[it.text_byte]);
        end
        if (it.end_of_piece) begin
          if (piece_err != bpe_pkg::ST_OK) begin
            o.token_val = '0;
            o.last_token = 1'b1;
            o.status = piece_err;
            owed_q.push_back(o);
          end else begin
            merge_span();
            foreach (span_q[i]) begin
              o.token_val = span_q[i];
              o.last_token = (i == span_q.size() - 1);
              o.status = bpe_pkg::ST_OK;
              owed_q.push_back(o);
            end
          end
          piece_err = bpe_pkg::ST_OK;
          span_q.delete();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_token(input bpe_pkg::out_t got);
    bpe_pkg::out_t want;
    if (owed_q.size() == 0) begin
      $display("%0t: unexpected token id=%0h last=%0b status=%0d", $realtime,
               got.token_val, got.last_token, got.status);
      mismatches++;
      return;
    end
    want = owed_q.pop_front();
    if (got.token_val !== want.token_val || got.last_token !== want.last_token ||
        got.status !== want.status) begin
      $display("%0t: token mismatch: expected id=%0h last=%0b status=%0d,",
               $realtime, want.token_val, want.last_token, want.status,
               " got id=%0h last=%0b status=%0d",
               got.token_val, got.last_token, got.status);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    tokens_owed = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (byte_known[i]) byte_known[i] = 1'b0;
      span_q.delete();
      owed_q.delete();
      piece_err = bpe_pkg::ST_OK;
      search_limit = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0)
        search_limit = (pwdata[16:0] > 65536) ? 65536 : int'(pwdata[16:0]);
      if (in_valid && in_ready) predict_item(in_data);
      if (out_valid && out_ready) check_token(out_data);
    end
    tokens_owed = owed_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives the merge engine with table loads, byte map loads and text pieces
// under random gaps and back-pressure; the checker predicts every token.
// ---------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT = 400000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  bpe_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  bpe_pkg::out_t out_data;
  logic          psel, penable, pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  int mismatches;
  int tokens_owed;
  int items_sent;     // items accepted by the engine so far
  int table_size;     // entries in the current sorted merge table
  bit steady;         // suppress all gaps on the sending side
  bit hold_req;       // ask the receiver for one long hold-off
  int quiet_cycles;

  bpe_merge_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bpe_merge_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .tokens_owed(tokens_owed)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: runs of ready, short stalls, the odd long one, and a single
  // long hold-off on request so that the engine backs up into its input.
  int  stall_left;
  int  run_left;
  bit  hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      run_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      stall_left <= 600;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left <= run_left - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      out_ready <= (r < 70);
      if (r < 70) run_left <= $urandom_range(1, 25);
      else if (r < 95) stall_left <= $urandom_range(1, 3);
      else stall_left <= $urandom_range(20, 80);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item after a random gap; hold it until it is taken.
  task automatic push_item(input bpe_pkg::in_t it);
    int gap, r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Unused fields carry random bits so that every input bit toggles.
  function automatic bpe_pkg::in_t noise_fields();
    logic [127:0] raw;
    bpe_pkg::in_t it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(bpe_pkg::in_t)-1:0];
    return it;
  endfunction

  task automatic send_text(input logic [7:0] b, input bit eop);
    bpe_pkg::in_t it;
    it = noise_fields();
    it.opcode = bpe_pkg::OP_TEXT;
    it.text_byte = b;
    it.end_of_piece = eop;
    push_item(it);
  endtask

  task automatic send_map(input int idx, input bit present, input logic [17:0] tok);
    bpe_pkg::in_t it;
    it = noise_fields();
    it.opcode = bpe_pkg::OP_MAP;
    it.table_index = 16'(idx);
    it.byte_present = present;
    it.result_id = tok;
    push_item(it);
  endtask

  task automatic send_merge(input int idx, input logic [17:0] l, input logic [17:0] r,
                            input logic [17:0] res, input logic [17:0] rank);
    bpe_pkg::in_t it;
    it = noise_fields();
    it.opcode = bpe_pkg::OP_MERGE;
    it.table_index = 16'(idx);
    it.left_id = l;
    it.right_id = r;
    it.result_id = res;
    it.merge_rank = rank;
    push_item(it);
  endtask

  // Mapped bytes: 0..7 to tokens 0..7, 0xff to the widest token.
  function automatic logic [7:0] good_byte();
    int k;
    k = $urandom_range(0, 8);
    return (k == 8) ? 8'hff : 8'(k);
  endfunction

  task automatic send_piece(input int len, input int bad_pct);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 99) < bad_pct) ? 8'($urandom) : good_byte();
      send_text(b, i == len - 1);
    end
  endtask

  // Drain: drop valid, wait for every owed token, then let the engine settle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Fill a table sorted by pair over the token alphabet 0..15, close it
  // with the widest pair, and return its size. Ties in rank come often
  // when tie_heavy is set.
  task automatic build_table(input int cap, input bit tie_heavy, output int n);
    logic [17:0] res, rank;
    n = 0;
    for (int l = 0; l < 16; l++) begin
      for (int r = 0; r < 16; r++) begin
        if (n < cap && $urandom_range(0, 4) == 0) begin
          res = ($urandom_range(0, 4) == 0) ? 18'($urandom) : 18'($urandom_range(8, 15));
          rank = tie_heavy ? 18'($urandom_range(0, 3)) : 18'($urandom);
          send_merge(n, 18'(l), 18'(r), res, rank);
          n++;
        end
      end
    end
    send_merge(n, 18'h3ffff, 18'h3ffff, 18'($urandom), 18'($urandom));
    n++;
  endtask

  initial begin
    bpe_pkg::in_t it;
    int k;
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 0;
    hold_req = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte map, ignored items, a first table
    for (int b = 0; b < 8; b++) send_map(b, 1'b1, 18'(b));
    send_map(255, 1'b1, 18'h3ffff);
    send_map(8, 1'b0, 18'h3ffff);
    send_map(300, 1'b1, 18'h00001);        // index beyond the map: dropped
    it = noise_fields();
    it.opcode = 2'd3;                      // unused opcode: dropped
    push_item(it);
    build_table(24, 1'b1, table_size);
    settle();
    write_count(table_size);

    send_piece(1, 0);
    send_text(8'd0, 1'b0);
    send_text(8'd1, 1'b1);
    send_text(8'hff, 1'b0);
    send_text(8'hff, 1'b0);
    send_text(8'd0, 1'b1);
    // byte without a token; the piece yields only an error result
    send_text(8'd2, 1'b0);
    send_text(8'd200, 1'b0);
    send_text(8'd3, 1'b1);
    send_piece(65, 0);                     // one byte too many for the span
    send_piece(64, 0);                     // full span, no error
    settle();

    // No merges searched at all
    write_count(0);
    send_piece(4, 0);
    settle();

    // Count above the table depth saturates; single bytes and broken pieces
    // never search, so the unloaded entries stay untouched.
    write_count(32'h1ffff);
    send_piece(1, 0);
    send_text(8'd9, 1'b1);
    settle();
    write_count(32'hfffe_0000 | table_size);
    send_piece(3, 0);
    settle();

    // Random phases
    k = 0;
    while (k < 3 || items_sent < 270) begin
      if ($urandom_range(0, 2) == 0)
        build_table($urandom_range(4, 60), 1'($urandom_range(0, 1)), table_size);
      settle();
      write_count(($urandom_range(0, 3) == 0) ? $urandom_range(0, table_size) : table_size);
      steady = (k == 2);
      if (k == 1) hold_req = 1;
      for (int p = $urandom_range(3, 5); p > 0; p--) begin
        case ($urandom_range(0, 19))
          0: begin
            it = noise_fields();
            it.opcode = 2'd3;
            push_item(it);
          end
          1: send_map($urandom_range(256, 65535), 1'($urandom), 18'($urandom));
          2: send_merge($urandom_range(200, 65535), 18'($urandom), 18'($urandom),
                        18'($urandom), 18'($urandom));
          3: send_map($urandom_range(0, 7), 1'b1, 18'($urandom_range(0, 15)));
          4: send_piece($urandom_range(20, 40), 0);
          5: send_piece($urandom_range(1, 6), 30);
          default: send_piece($urandom_range(1, 8), 2);
        endcase
      end
      steady = 0;
      k++;
    end
    settle();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bpe_pkg.sv
hdl/bpe_ctrl.sv
hdl/bpe_dp.sv
hdl/bpe_merge_engine.sv
hdl/bpe_checker.sv
tb/bpe_merge_checker.sv
tb/tb.sv
